// File: rtl/core/countdown_stopwatch_timer_macros.svh
// Assertion macros for the countdown timer and stopwatch.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef COUNTDOWN_STOPWATCH_TIMER_MACROS_SVH
`define COUNTDOWN_STOPWATCH_TIMER_MACROS_SVH

`ifndef SYNTH
// Check that cons holds in every cycle where ante holds
`define CDSW_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdsw: implication check failed");
// Check that cond never holds
`define CDSW_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cdsw: forbidden condition seen");
`else
`define CDSW_ASSERT_IMPLIES(label, ante, cons)
`define CDSW_ASSERT_NEVER(label, cond)
`endif

`endif

// File: rtl/core/cdsw_pkg.sv
`timescale 1ns / 1ps

package cdsw_pkg;

  // Run status codes, also the status reported on the result channel
  typedef enum logic [2:0] {
    ST_OFF      = 3'd0,
    ST_CD_RUN   = 3'd1,
    ST_CD_PAUSE = 3'd2,
    ST_SW_RUN   = 3'd3,
    ST_SW_PAUSE = 3'd4
  } run_state_t;

  // Command codes; the remaining codes do nothing
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_START_CD   = 3'd1,
    CMD_START_SW   = 3'd2,
    CMD_PLAY_PAUSE = 3'd3,
    CMD_STOP       = 3'd4
  } cmd_t;

  localparam logic [15:0] INTERVAL_RESET = 16'd1000;
  localparam logic [15:0] MS_PER_MIN     = 16'd60000;

  // Reciprocal constants: x / 1000 = (x * DIV1000_MAGIC) >> 38 for 32-bit x,
  // x / 60 = (x * DIV60_MAGIC_S) >> 28 for x below 6000000,
  // x / 60 = (x * DIV60_MAGIC_M) >> 22 for x below 74000
  localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
  localparam logic [22:0] DIV60_MAGIC_S = 23'd4473925;
  localparam logic [16:0] DIV60_MAGIC_M = 17'd69906;

  // Timer state captured after one item
  typedef struct packed {
    run_state_t  state;
    logic [31:0] clock_ms;
    logic [31:0] mark_time;
    logic [31:0] pause_time;
    logic        pulse;
  } snap_t;

  // Result fields known before the display split
  typedef struct packed {
    run_state_t  status;
    logic        overrun;
    logic [31:0] time_ms;
    logic        changed;
  } res_t;

endpackage

// File: rtl/core/countdown_stopwatch_timer.sv
`timescale 1ns / 1ps

// Countdown timer and stopwatch on a millisecond clock.
// Input channel (in_valid/in_ready): one command per transfer; tick advances
// the clock by 1 ms, others start a countdown of in_start_minutes, start the
// stopwatch, toggle play/pause, or stop.
// Result channel (out_valid/out_ready): one result per command with status,
// overrun, time in ms, display minutes and seconds, and the changed pulse.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; a transfer
// sets the changed interval in ms. Write it only while the block is idle.
// Path: a state update stage, a time/overrun stage, three reciprocal
// multiply stages, the last of which also forms the seconds digit, and a
// final subtract stage that forms the minutes digit.
// Throughput: one command per cycle; every stage is elastic, so a stalled
// receiver backs up the pipeline one stage at a time and in_ready drops only
// once all six stages are full.
// Reset: status off, all times zero, interval 1000 ms, pipeline empty.
module countdown_stopwatch_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [9:0]  in_start_minutes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_overrun,
  output logic [31:0] out_time_ms,
  output logic [5:0]  out_display_minutes,
  output logic [5:0]  out_display_seconds,
  output logic        out_changed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_change_interval_ms
);
  import cdsw_pkg::*;

  logic  snap_valid, snap_ready;
  snap_t snap;
  logic  res_valid, res_ready;
  res_t  res;
  res_t  out_res;
  logic  cd_status;
  logic  run_status;
  logic  digit_wide;

  cdsw_state u_state (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_command             (in_command),
    .in_start_minutes       (in_start_minutes),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_change_interval_ms (cfg_change_interval_ms),
    .snap_valid             (snap_valid),
    .snap_ready             (snap_ready),
    .snap                   (snap)
  );

  cdsw_time u_time (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  cdsw_digits u_digits (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (out_res),
    .out_minutes (out_display_minutes),
    .out_seconds (out_display_seconds)
  );

  assign out_status  = out_res.status;
  assign out_overrun = out_res.overrun;
  assign out_time_ms = out_res.time_ms;
  assign out_changed = out_res.changed;

  // Status classes and digit range seen on the result channel
  assign cd_status  = out_status == ST_CD_RUN || out_status == ST_CD_PAUSE;
  assign run_status = out_status == ST_CD_RUN || out_status == ST_SW_RUN;
  assign digit_wide = out_display_minutes > 6'd59 || out_display_seconds > 6'd59;

`include "countdown_stopwatch_timer_macros.svh"

  // Overrun only while a countdown is active
  `CDSW_ASSERT_IMPLIES(a_overrun_cd, out_valid && out_overrun, cd_status)
  // The changed pulse only comes while running
  `CDSW_ASSERT_IMPLIES(a_changed_run, out_valid && out_changed, run_status)
  // Off reports zero time
  `CDSW_ASSERT_IMPLIES(a_off_zero, out_valid && out_status == ST_OFF, out_time_ms == 32'd0)
  // Display digits stay below sixty
  `CDSW_ASSERT_NEVER(a_digit_range, out_valid && digit_wide)

endmodule

// File: rtl/core/cdsw_state.sv
`timescale 1ns / 1ps

module cdsw_state (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [9:0]         in_start_minutes,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_change_interval_ms,
  output logic               snap_valid,
  input  logic               snap_ready,
  output cdsw_pkg::snap_t    snap
);
  import cdsw_pkg::*;

  logic [15:0] interval_r;
  run_state_t  state_r, state_nxt;
  logic [31:0] clock_r, clock_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic [31:0] pause_r, pause_nxt;
  logic [31:0] last_r, last_nxt;
  logic        pulse_nxt;
  logic        snap_v_r;
  snap_t       snap_r;
  cmd_t        cmd;
  logic [31:0] clock_inc;
  logic [31:0] change_lim;
  logic [25:0] cd_len;
  logic        accept;

  assign cmd        = cmd_t'(in_command);
  assign in_ready   = !snap_v_r || snap_ready;
  assign accept     = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

  assign clock_inc  = clock_r + 32'd1;
  assign change_lim = last_r + {16'd0, interval_r};
  assign cd_len     = {16'd0, in_start_minutes} * {10'd0, MS_PER_MIN};

  // Apply one command to the timer state
  always_comb begin
    state_nxt = state_r;
    clock_nxt = clock_r;
    mark_nxt  = mark_r;
    pause_nxt = pause_r;
    last_nxt  = last_r;
    pulse_nxt = 1'b0;
    case (cmd)
      CMD_TICK: begin
        clock_nxt = clock_inc;
        if ((state_r == ST_CD_RUN || state_r == ST_SW_RUN) && clock_inc > change_lim) begin
          last_nxt  = clock_inc;
          pulse_nxt = 1'b1;
        end
      end
      CMD_START_CD: begin
        mark_nxt  = clock_r + {6'd0, cd_len};
        state_nxt = ST_CD_RUN;
        last_nxt  = clock_r;
      end
      CMD_START_SW: begin
        mark_nxt  = clock_r;
        state_nxt = ST_SW_RUN;
        last_nxt  = clock_r;
      end
      CMD_PLAY_PAUSE: begin
        case (state_r)
          ST_CD_RUN: begin
            state_nxt = ST_CD_PAUSE;
            pause_nxt = clock_r;
          end
          ST_SW_RUN: begin
            state_nxt = ST_SW_PAUSE;
            pause_nxt = clock_r;
          end
          ST_CD_PAUSE: begin
            state_nxt = ST_CD_RUN;
            mark_nxt  = mark_r + (clock_r - pause_r);
          end
          ST_SW_PAUSE: begin
            state_nxt = ST_SW_RUN;
            mark_nxt  = mark_r + (clock_r - pause_r);
          end
          default: begin
            state_nxt = state_r;
          end
        endcase
      end
      CMD_STOP: begin
        state_nxt = ST_OFF;
        mark_nxt  = 32'd0;
        pause_nxt = 32'd0;
        last_nxt  = 32'd0;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  // Hold timer state and the change interval
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
      state_r    <= ST_OFF;
      clock_r    <= 32'd0;
      mark_r     <= 32'd0;
      pause_r    <= 32'd0;
      last_r     <= 32'd0;
    end else begin
      if (cfg_valid) begin
        interval_r <= cfg_change_interval_ms;
      end
      if (accept) begin
        state_r <= state_nxt;
        clock_r <= clock_nxt;
        mark_r  <= mark_nxt;
        pause_r <= pause_nxt;
        last_r  <= last_nxt;
      end
    end
  end

  // Capture the updated state for the result path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (in_ready) begin
      snap_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snap_r.state      <= state_nxt;
      snap_r.clock_ms   <= clock_nxt;
      snap_r.mark_time  <= mark_nxt;
      snap_r.pause_time <= pause_nxt;
      snap_r.pulse      <= pulse_nxt;
    end
  end

endmodule

// File: rtl/core/cdsw_time.sv
`timescale 1ns / 1ps

module cdsw_time (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            snap_valid,
  output logic            snap_ready,
  input  cdsw_pkg::snap_t snap,
  output logic            res_valid,
  input  logic            res_ready,
  output cdsw_pkg::res_t  res
);
  import cdsw_pkg::*;

  logic        res_v_r;
  res_t        res_r;
  logic [31:0] ref_ms;
  logic        over;
  logic [31:0] t_ms;

  assign snap_ready = !res_v_r || res_ready;
  assign res_valid  = res_v_r;
  assign res        = res_r;

  // Pick the running clock or the pause instant as the reference
  assign ref_ms = (snap.state == ST_CD_RUN || snap.state == ST_SW_RUN) ?
                  snap.clock_ms : snap.pause_time;

  // Countdown overrun and time left, past zero or elapsed
  always_comb begin
    over = 1'b0;
    t_ms = 32'd0;
    case (snap.state)
      ST_CD_RUN, ST_CD_PAUSE: begin
        over = snap.mark_time < ref_ms;
        t_ms = over ? (ref_ms - snap.mark_time) : (snap.mark_time - ref_ms);
      end
      ST_SW_RUN, ST_SW_PAUSE: begin
        t_ms = ref_ms - snap.mark_time;
      end
      default: begin
        t_ms = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (snap_ready) begin
      res_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      res_r.status  <= snap.state;
      res_r.overrun <= over;
      res_r.time_ms <= t_ms;
      res_r.changed <= snap.pulse;
    end
  end

endmodule

// File: rtl/core/cdsw_digits.sv
`timescale 1ns / 1ps

module cdsw_digits (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  output logic           res_ready,
  input  cdsw_pkg::res_t res,
  output logic           out_valid,
  input  logic           out_ready,
  output cdsw_pkg::res_t out_res,
  output logic [5:0]     out_minutes,
  output logic [5:0]     out_seconds
);
  import cdsw_pkg::*;

  // Stage A: seconds = time / 1000
  logic        va_r;
  res_t        res_a_r;
  logic [22:0] secs_a_r;
  logic [60:0] prod_a;
  // Stage B: total minutes = seconds / 60
  logic        vb_r;
  res_t        res_b_r;
  logic [22:0] secs_b_r;
  logic [16:0] mtot_b_r;
  logic [45:0] prod_b;
  // Stage C: seconds digit, hours = minutes / 60
  logic        vc_r;
  res_t        res_c_r;
  logic [5:0]  sec_c_r;
  logic [16:0] mtot_c_r;
  logic [11:0] hrs_c_r;
  logic [33:0] prod_c;
  logic [22:0] sec_diff;
  // Stage D: minutes digit, result register
  logic        vd_r;
  res_t        res_d_r;
  logic [5:0]  sec_d_r;
  logic [5:0]  min_d_r;
  logic [17:0] min_diff;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // Ready travels back through the stages
  assign rdy_d     = !vd_r || out_ready;
  assign rdy_c     = !vc_r || rdy_d;
  assign rdy_b     = !vb_r || rdy_c;
  assign rdy_a     = !va_r || rdy_b;
  assign res_ready = rdy_a;

  assign prod_a   = {29'd0, res.time_ms} * {32'd0, DIV1000_MAGIC};
  assign prod_b   = {23'd0, secs_a_r} * {23'd0, DIV60_MAGIC_S};
  assign prod_c   = {17'd0, mtot_b_r} * {17'd0, DIV60_MAGIC_M};
  assign sec_diff = secs_b_r - ({mtot_b_r, 6'd0} - {4'd0, mtot_b_r, 2'd0});
  assign min_diff = {1'b0, mtot_c_r} - ({hrs_c_r, 6'd0} - {4'd0, hrs_c_r, 2'd0});

  // Advance stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= res_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  // Stage payloads load on a transfer into the stage
  always_ff @(posedge clk) begin
    if (res_valid && rdy_a) begin
      res_a_r  <= res;
      secs_a_r <= prod_a[60:38];
    end
    if (va_r && rdy_b) begin
      res_b_r  <= res_a_r;
      secs_b_r <= secs_a_r;
      mtot_b_r <= prod_b[44:28];
    end
    if (vb_r && rdy_c) begin
      res_c_r  <= res_b_r;
      sec_c_r  <= sec_diff[5:0];
      mtot_c_r <= mtot_b_r;
      hrs_c_r  <= prod_c[33:22];
    end
    if (vc_r && rdy_d) begin
      res_d_r <= res_c_r;
      sec_d_r <= sec_c_r;
      min_d_r <= min_diff[5:0];
    end
  end

  assign out_valid   = vd_r;
  assign out_res     = res_d_r;
  assign out_minutes = min_d_r;
  assign out_seconds = sec_d_r;

endmodule
